>>> sv/sync_length_checksum_deframer_defines.svh
// Assertion macros for the sync/length/checksum deframer.
// Used by the top level only; SYNTH selects the empty forms.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`ifndef SYNTH
`define SLD_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sld: assertion failed");
`define SLD_ASSERT_RST(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("sld: reset assertion failed");
`else
`define SLD_ASSERT(name, prop)
`define SLD_ASSERT_RST(name, prop)
`endif
`endif

>>> sv/sld_pkg.sv
// Shared constants and types for the sync/length/checksum deframer.
// No dependencies.
package sld_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 100;
    localparam int unsigned POS_W           = 7;
    localparam int unsigned VALUE_BYTES     = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam logic [POS_W-1:0] POS_HUNT_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HUNT_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LENGTH      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_COMMAND     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PAYLOAD     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LIMIT       = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_VALUE_END   = POS_W'(4 + VALUE_BYTES);

    typedef struct packed {
        logic [7:0]  frame_command;
        logic [6:0]  payload_length;
        logic        checksum_good;
        logic        length_over_four;
        logic [31:0] payload_value;
    } sld_result_t;

endpackage

>>> sv/sync_length_checksum_deframer.sv
// Sync/length/checksum deframer top level. Depends on sld_pkg, sld_parser
// and the defines header. The checksum byte enters the input register at its
// transfer; the result register captures the result when the parser steps on
// it, which can stall while a result is held. Throughput: one byte per cycle;
// the parser advances whenever the result register is empty or being drained.
// Reset (aresetn, synchronous, active low) clears both valid flags; parser hunts sync.
`include "sync_length_checksum_deframer_defines.svh"
module sync_length_checksum_deframer import sld_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_command,
    output logic [6:0]  m_payload_length,
    output logic        m_checksum_good,
    output logic        m_length_over_four,
    output logic [31:0] m_payload_value
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        m_valid_reg;
    sld_result_t out_reg;
    logic        advance;
    logic        res_fire;
    sld_result_t res;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    sld_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .rx_byte      (byte_reg),
        .result_valid (res_fire),
        .result       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_fire;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_fire) begin
            out_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_frame_command    = out_reg.frame_command;
    assign m_payload_length   = out_reg.payload_length;
    assign m_checksum_good    = out_reg.checksum_good;
    assign m_length_over_four = out_reg.length_over_four;
    assign m_payload_value    = out_reg.payload_value;

    `SLD_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid)
    `SLD_ASSERT(a_len_bound, m_valid |-> (m_payload_length <= 7'(MAX_FRAME_BYTES - 5)))
    `SLD_ASSERT(a_over_flag, m_valid |-> (m_length_over_four == (m_payload_length > 7'd4)))
    `SLD_ASSERT(a_over_value, (m_valid && m_length_over_four) |-> (m_payload_value == 32'd0))

endmodule

>>> sv/sld_parser.sv
// Frame parser: sync hunt, length/command capture, running checksum and
// value accumulation, one byte per step. Depends on sld_pkg.
module sld_parser import sld_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    output sld_result_t result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       sum_reg, sum_next;
    logic [31:0]      acc_reg, acc_next;
    logic [7:0]       sum_add;
    logic             at_end;
    logic             over;

    assign sum_add = sum_reg + rx_byte;
    assign at_end  = {2'b00, pos_reg} >= ({1'b0, len_reg} + 9'd4);
    assign over    = len_reg > 8'(VALUE_BYTES);

    always_comb begin
        result.frame_command    = cmd_reg;
        result.payload_length   = len_reg[6:0];
        result.checksum_good    = (sum_add == 8'd0);
        result.length_over_four = over;
        result.payload_value    = (over || len_reg == 8'd0) ? 32'd0 : acc_reg;
    end

    always_comb begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        cmd_next     = cmd_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        result_valid = 1'b0;
        if (step) begin
            if (pos_reg >= POS_LIMIT) begin
                pos_next = POS_HUNT_FIRST;
            end else if (pos_reg == POS_HUNT_FIRST) begin
                if (rx_byte == SYNC_FIRST) begin
                    sum_next = rx_byte;
                    pos_next = POS_HUNT_SECOND;
                end
            end else if (pos_reg == POS_HUNT_SECOND) begin
                if (rx_byte == SYNC_SECOND) begin
                    sum_next = sum_add;
                    pos_next = POS_LENGTH;
                end else begin
                    pos_next = POS_HUNT_FIRST;
                end
            end else if (pos_reg == POS_LENGTH) begin
                len_next = rx_byte;
                sum_next = sum_add;
                pos_next = POS_COMMAND;
            end else if (pos_reg == POS_COMMAND) begin
                cmd_next = rx_byte;
                sum_next = sum_add;
                acc_next = 32'd0;
                pos_next = POS_PAYLOAD;
            end else if (at_end) begin
                result_valid = 1'b1;
                pos_next     = POS_HUNT_FIRST;
            end else begin
                sum_next = sum_add;
                if (pos_reg < POS_VALUE_END) begin
                    acc_next = {acc_reg[23:0], rx_byte};
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT_FIRST;
            len_reg <= 8'd0;
            cmd_reg <= 8'd0;
            sum_reg <= 8'd0;
            acc_reg <= 32'd0;
        end else begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            cmd_reg <= cmd_next;
            sum_reg <= sum_next;
            acc_reg <= acc_next;
        end
    end

endmodule
